// ----- hw/rtl/stream_find_replace_core_assert.svh -----
// Assertion macros for the find-and-replace core.
// Depends on nothing; included by the top level only.
`ifndef STREAM_FIND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace core.
// No dependencies; imported by every module of the block.
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int JOB_BYTES       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                     : MAX_REPLACEMENT;
    localparam int PAT_W           = MAX_PATTERN * BYTE_W;
    localparam int REP_W           = MAX_REPLACEMENT * BYTE_W;
    localparam int JOB_W           = JOB_BYTES * BYTE_W;
    localparam int LEN_W           = $clog2(JOB_BYTES + 1);
    localparam int PEND_W          = $clog2(MAX_PATTERN);
    localparam int IDX_W           = $clog2(JOB_BYTES);
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] NUL_BYTE = '0;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern_bytes;
        logic [3:0]       pattern_length;
        logic [REP_W-1:0] replacement_bytes;
        logic [3:0]       replacement_length;
    } cfg_t;

    // One burst of output bytes; count zero with end set is a bare end marker.
    typedef struct packed {
        logic [JOB_W-1:0] bytes;
        logic [LEN_W-1:0] count;
        logic             str_end;
    } job_t;

    typedef struct packed {
        logic [PEND_W-1:0] pend_count;
    } front_stat_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

// ----- hw/rtl/sfr_front.sv -----
// Front end: holds the pending prefix, matches each byte, emits a job descriptor.
// Depends on sfr_pkg.
module sfr_front
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    input  logic              in_empty,
    output job_t              job,
    output logic              job_valid,
    output front_stat_t       stat
);

    logic [PAT_W-1:0]  pend_buf_reg, pend_buf_next;
    logic [PEND_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic [PAT_W-1:0]   work;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   rlen;
    logic [MAX_PATTERN:0] ok;
    logic [LEN_W-1:0]   sel;
    logic [LEN_W-1:0]   r_sel;
    logic               match;

    always_comb begin
        plen = (cfg.pattern_length == 4'd0) ? LEN_W'(1) :
               (cfg.pattern_length > 4'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) :
               LEN_W'(cfg.pattern_length);
        rlen = (cfg.replacement_length > 4'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) :
               LEN_W'(cfg.replacement_length);
    end

    // work = pending bytes with the new byte appended
    always_comb begin
        work = pend_buf_reg;
        work[{pend_cnt_reg, 3'b000} +: BYTE_W] = in_byte;
        len  = LEN_W'(pend_cnt_reg) + LEN_W'(1);
    end

    // candidate s: drop s leading bytes, the rest must be a pattern prefix
    always_comb begin
        logic [LEN_W-1:0] r;
        logic             hit;
        for (int s = 0; s <= MAX_PATTERN; s++) begin
            r   = len - LEN_W'(s);
            hit = 1'b1;
            if (LEN_W'(s) > len) hit = 1'b0;
            if (r > plen) hit = 1'b0;
            if ((r == plen) && (s != 0)) hit = 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if ((LEN_W'(i) < r) && (s + i < MAX_PATTERN)) begin
                    if (work[((s + i) % MAX_PATTERN) * BYTE_W +: BYTE_W] !=
                        cfg.pattern_bytes[i * BYTE_W +: BYTE_W]) begin
                        hit = 1'b0;
                    end
                end
            end
            ok[s] = hit;
        end
    end

    always_comb begin
        logic found;
        found = 1'b0;
        sel   = LEN_W'(MAX_PATTERN);
        for (int s = 0; s <= MAX_PATTERN; s++) begin
            if (ok[s] && !found) begin
                sel   = LEN_W'(s);
                found = 1'b1;
            end
        end
        r_sel = len - sel;
        match = ok[0] && (len == plen);
    end

    always_comb begin
        pend_buf_next = pend_buf_reg;
        pend_cnt_next = pend_cnt_reg;
        job.bytes     = work;
        job.count     = '0;
        job.str_end   = in_end;
        if (in_empty) begin
            // no byte carried: only an end flushes, otherwise nothing happens
            job.bytes = pend_buf_reg;
            if (in_end) begin
                job.count     = LEN_W'(pend_cnt_reg);
                pend_cnt_next = '0;
            end
        end else if (match) begin
            job.bytes     = JOB_W'(cfg.replacement_bytes);
            job.count     = rlen;
            pend_cnt_next = '0;
        end else begin
            job.count     = in_end ? len : sel;
            pend_buf_next = work >> {sel, 3'b000};
            pend_cnt_next = in_end ? '0 : r_sel[PEND_W-1:0];
        end
        job_valid = in_fire && ((job.count != '0) || in_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= '0;
        end else if (in_fire) begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pend_buf_reg <= pend_buf_next;
        end
    end

    assign stat.pend_count = pend_cnt_reg;

endmodule

// ----- hw/rtl/sfr_queue.sv -----
// Short job queue between front and back ends.
// Depends on sfr_pkg.
module sfr_queue
    import sfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t stat
);

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + Q_CNT_W'(1);
        if (pop && !push) cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job       = mem_reg[rd_ptr_reg];
    assign stat.full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.not_empty = (cnt_reg != '0);

endmodule

// ----- hw/rtl/sfr_back.sv -----
// Back end: plays out one job a byte per transaction on the result stream.
// Depends on sfr_pkg.
module sfr_back
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  job_t              head_job,
    input  q_stat_t           q_stat,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              byte_valid,
    output logic              run_last,
    output logic              string_end
);

    job_t             cur_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             fire;
    logic             last;

    assign last = (cur_reg.count == '0) ||
                  ((LEN_W'(idx_reg) + LEN_W'(1)) == cur_reg.count);
    assign fire = busy_reg && m_tready;
    assign pop  = q_stat.not_empty && (!busy_reg || (fire && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (!busy_reg || (fire && last)) begin
            busy_reg <= q_stat.not_empty;
            idx_reg  <= '0;
        end else if (fire) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_job;
        end
    end

    assign m_tvalid   = busy_reg;
    assign byte_valid = (cur_reg.count != '0);
    assign out_byte   = byte_valid ? cur_reg.bytes[{idx_reg, 3'b000} +: BYTE_W] : NUL_BYTE;
    assign run_last   = last;
    assign string_end = last && cur_reg.str_end;

endmodule

// ----- hw/rtl/stream_find_replace_core.sv -----
// Top level of the stream find-and-replace core: configuration registers,
// front end, job queue and back end. Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back and the assertion header.
//
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   tdata[7:0] in_byte, tlast in_end, tuser in_empty
// m_       out  m_tvalid/m_tready   tdata[7:0] out_byte, tlast run_last,
//                                   tuser[0] byte_valid, tuser[1] string_end
// cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// The front end takes one input transaction per cycle while the two-entry job
// queue has room; matching and the pending update complete in that cycle.
// The back end sends one result per cycle while m_tready is high, so an input with k
// results (1 to 8) holds the output for all k; inputs giving none are never queued.
// Reset is synchronous, active low: pending count, queue and back end clear,
// registers return to a one-byte zero pattern and an empty replacement.
// Output stalls back up through the queue to s_tready; cfg_ready is always high.
`include "stream_find_replace_core_assert.svh"

module stream_find_replace_core
    import sfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // in_end
    input  logic        s_tuser,    // in_empty
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser,    // [0] byte_valid, [1] string_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        s_fire;
    job_t        f_job;
    logic        f_job_valid;
    front_stat_t f_stat;
    job_t        q_head;
    q_stat_t     q_stat;
    logic        q_pop;

    // Configuration: always ready; the user writes it only while the block is idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= 4'd1;
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_PATTERN_BYTES:      cfg_reg.pattern_bytes      <= cfg_data[PAT_W-1:0];
                REG_PATTERN_LENGTH:     cfg_reg.pattern_length     <= cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes  <= cfg_data[REP_W-1:0];
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Front accepts whenever the queue can take a job.
    assign s_tready = !q_stat.full;
    assign s_fire   = s_tvalid && s_tready;

    sfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_fire   (s_fire),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .in_empty  (s_tuser),
        .job       (f_job),
        .job_valid (f_job_valid),
        .stat      (f_stat)
    );

    sfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_job_valid),
        .push_job (f_job),
        .pop      (q_pop),
        .head_job (q_head),
        .stat     (q_stat)
    );

    sfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_byte   (m_tdata),
        .byte_valid (m_tuser[0]),
        .run_last   (m_tlast),
        .string_end (m_tuser[1])
    );

    // A job is never pushed into a full queue.
    `SFR_ASSERT_NOW(a_no_overflow, aclk, aresetn, f_job_valid, !q_stat.full)
    // End of string always empties the pending prefix.
    `SFR_ASSERT_NEXT(a_end_flushes, aclk, aresetn, s_fire && s_tlast,
                     f_stat.pend_count == '0)
    // String end only ever on the last result of its input.
    `SFR_ASSERT_NOW(a_end_is_run_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for stream_find_replace_core: directed table, then random phases.
// Needs sfr_pkg and the core RTL; carries its own byte-level model of the rewrite.
module tb_top;
    import sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 29;
    localparam int DRAIN_CYCLES    = 16;    // quiet time before a register write
    localparam int TAIL_CYCLES     = 32;    // quiet time at the end of the run
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no transaction anywhere
    localparam int MAX_REPORTS     = 40;
    localparam int FROM_MODEL      = -1;    // row result comes from the predictor

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One result transaction, fields as they appear on the m_ side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } result_t;

    // One row of the directed table: either a register write or an input transaction
    typedef struct {
        bit          is_write;
        cfg_index_t  reg_idx;
        logic [63:0] wdata;
        logic [7:0]  in_byte;
        logic        in_end;
        logic        in_empty;
        int          exp_n;     // FROM_MODEL, or 0/1 results typed in below
        result_t     exp_r;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    stream_find_replace_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copies and the pending match buffer
    // ------------------------------------------------------------------
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = 4'd0;
    logic [7:0]  pend_buf [0:MAX_PATTERN-1];
    int          pend_cnt  = 0;

    result_t     step_out[$];            // results of the transaction just predicted
    result_t     expected_bytes_q[$];    // results still owed by the block
    dir_row_t    dir_rows[$];
    logic [7:0]  plan_q[$];              // bytes queued up to plant pattern hits

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          n_items  = 0;
    int          n_results = 0;
    int          n_writes = 0;
    int          n_errors = 0;
    int          quiet_cycles = 0;
    result_t     got_r;
    result_t     want_r;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int clamp_len(input logic [3:0] v, input int lo, input int hi);
        if (int'(v) < lo) return lo;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic void emit_byte(input logic [7:0] d, input logic v);
        step_out.push_back('{d, v, 1'b0, 1'b0});
    endfunction

    function automatic void load_reg(input cfg_index_t idx, input logic [63:0] v);
        case (idx)
            REG_PATTERN_BYTES:      pat_bytes = v;
            REG_PATTERN_LENGTH:     pat_len   = v[3:0];
            REG_REPLACEMENT_BYTES:  rep_bytes = v;
            REG_REPLACEMENT_LENGTH: rep_len   = v[3:0];
            default: ;
        endcase
    endfunction

    // Advance the model by one input transaction; results land in step_out.
    function automatic void rewrite_byte(input logic [7:0] b, input logic e,
                                         input logic emp);
        logic [7:0] work [0:MAX_PATTERN-1];
        int plen, rlen, len, s, r, i, k;
        bit found, ok;
        plen = clamp_len(pat_len, 1, MAX_PATTERN);
        rlen = clamp_len(rep_len, 0, MAX_REPLACEMENT);
        step_out.delete();
        if (!emp) begin
            for (i = 0; i < pend_cnt; i++) work[i] = pend_buf[i];
            work[pend_cnt] = b;
            len   = pend_cnt + 1;
            found = 1'b0;
            s     = len;
            // Leftmost split whose tail is a pattern prefix; a full match only
            // counts when nothing is pushed out ahead of it.
            for (k = 0; k <= len; k++) begin
                if (!found) begin
                    r  = len - k;
                    ok = (r <= plen) && !(r == plen && k != 0);
                    for (i = 0; i < r; i++)
                        if (ok && work[k + i] != pat_bytes[8*i +: 8]) ok = 1'b0;
                    if (ok) begin
                        found = 1'b1;
                        s     = k;
                    end
                end
            end
            r = len - s;
            for (i = 0; i < s; i++) emit_byte(work[i], 1'b1);
            if (r == plen) begin
                for (i = 0; i < rlen; i++) emit_byte(rep_bytes[8*i +: 8], 1'b1);
                pend_cnt = 0;
            end else begin
                for (i = 0; i < r; i++) pend_buf[i] = work[s + i];
                pend_cnt = r;
            end
        end
        if (e) begin
            for (i = 0; i < pend_cnt; i++) emit_byte(pend_buf[i], 1'b1);
            pend_cnt = 0;
            if (step_out.size() == 0) emit_byte(NUL_BYTE, 1'b0);
            step_out[step_out.size() - 1].string_end = 1'b1;
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_REPORTS) $display("tb_top: MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Result monitor: every accepted result is matched against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            n_results++;
            if (expected_bytes_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h flags %b%b%b",
                    got_r.out_byte, got_r.byte_valid, got_r.run_last, got_r.string_end));
            end else begin
                want_r = expected_bytes_q.pop_front();
                if (got_r.out_byte !== want_r.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                        got_r.out_byte, want_r.out_byte));
                if (got_r.byte_valid !== want_r.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b",
                        got_r.byte_valid, want_r.byte_valid));
                if (got_r.run_last !== want_r.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                        got_r.run_last, want_r.run_last));
                if (got_r.string_end !== want_r.string_end)
                    report_mismatch($sformatf("string_end %b, want %b",
                        got_r.string_end, want_r.string_end));
            end
        end
    end

    // Receiver back-pressure, redrawn each cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: any transaction on any channel resets the count
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: watchdog expired with %0d results owed",
                         expected_bytes_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic set_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default:       begin sender_idle_pct = 15; receiver_stall_pct = 15; end
        endcase
    endtask

    // Present one input transaction, wait for acceptance, then book its results.
    // Valid stays high into the next call unless that call opens with a gap.
    task automatic send_item(input logic [7:0] b, input logic e, input logic emp,
                             input int exp_n, input result_t exp_r);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        s_tuser  <= emp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rewrite_byte(b, e, emp);
        if (exp_n == FROM_MODEL)
            foreach (step_out[i]) expected_bytes_q.push_back(step_out[i]);
        else if (exp_n == 1)
            expected_bytes_q.push_back(exp_r);
        n_items++;
    endtask

    // Caller lowers cfg_valid after the last write of a batch.
    task automatic write_reg(input cfg_index_t idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_reg(idx, v);
        n_writes++;
    endtask

    // Stop sending and let the block run dry, including work that owes no result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    task automatic add_write(input cfg_index_t idx, input logic [63:0] v);
        dir_row_t row;
        row = '{1'b1, idx, v, 8'h00, 1'b0, 1'b0, 0, '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_item(input logic [7:0] b, input logic e, input logic emp,
                            input int exp_n, input result_t exp_r);
        dir_row_t row;
        row = '{1'b0, REG_PATTERN_BYTES, 64'h0, b, e, emp, exp_n, exp_r};
        dir_rows.push_back(row);
    endtask

    // Biased byte source: a few values recur so that prefixes overlap
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] v;
        logic [7:0]  b;
        logic        e, emp;
        int          plen, k, roll, ph, j;
        bit          in_cfg;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed table -------------------------------------------
        // Reset settings: pattern is a single zero byte, replacement empty
        add_item(8'h00, 1'b0, 1'b0, 0, '0);                          // deleted
        add_item(8'hFF, 1'b1, 1'b0, 1, '{8'hFF, 1'b1, 1'b1, 1'b1});
        add_item(8'h00, 1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1});  // bare end marker
        add_item(8'hFF, 1'b0, 1'b1, 0, '0);                          // empty, no end
        // Pattern "ABA" -> "XY": broken prefix then hit, leaves "AB" pending
        add_write(REG_PATTERN_BYTES,      64'h0000_0000_0041_4241);
        add_write(REG_PATTERN_LENGTH,     64'd3);
        add_write(REG_REPLACEMENT_BYTES,  64'h0000_0000_0000_5958);
        add_write(REG_REPLACEMENT_LENGTH, 64'd2);
        add_item(8'h41, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h41, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h42, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h41, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h41, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h42, 1'b0, 1'b0, FROM_MODEL, '0);
        // Change mid-string to "BC": pending "AB"+"C" holds the pattern, but only
        // after a leading byte, so all three go out unchanged.
        // Length writes carry junk above the low nibble; replacement length 15 is 8.
        add_write(REG_PATTERN_BYTES,      64'h0000_0000_0000_4342);
        add_write(REG_PATTERN_LENGTH,     64'hA5A5_A5A5_A5A5_A5A2);
        add_write(REG_REPLACEMENT_BYTES,  64'h0123_4567_89AB_CDEF);
        add_write(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_000F);
        add_item(8'h43, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h42, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h43, 1'b1, 1'b0, FROM_MODEL, '0);
        // Pattern length 0 acts as 1
        add_write(REG_PATTERN_BYTES,      64'hFFFF_FFFF_FFFF_FF42);
        add_write(REG_PATTERN_LENGTH,     64'h0);
        add_item(8'h42, 1'b1, 1'b0, FROM_MODEL, '0);
        // Pattern length 15 acts as 8; all-ones pattern, eight zero bytes replace it
        add_write(REG_PATTERN_BYTES,      64'hFFFF_FFFF_FFFF_FFFF);
        add_write(REG_PATTERN_LENGTH,     64'hF);
        add_write(REG_REPLACEMENT_BYTES,  64'h0);
        add_write(REG_REPLACEMENT_LENGTH, 64'd8);
        for (k = 0; k < 10; k++) add_item(8'hFF, 1'b0, 1'b0, FROM_MODEL, '0);
        add_item(8'h00, 1'b0, 1'b1, FROM_MODEL, '0);                 // ignored mid-string
        add_item(8'h00, 1'b1, 1'b0, FROM_MODEL, '0);                 // flush FF FF 00

        set_mode(IDLE_BOTH);
        in_cfg = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                if (!in_cfg) begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
            end else begin
                if (in_cfg) begin
                    cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_item(dir_rows[i].in_byte, dir_rows[i].in_end, dir_rows[i].in_empty,
                          dir_rows[i].exp_n, dir_rows[i].exp_r);
            end
        end

        // --- random phases ----------------------------------------------
        // Each phase: drain, load a fresh setting, then a mix of planted hits,
        // broken prefixes and plain bytes. Strings are left open across phases
        // so pending bytes meet the new pattern.
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            set_mode(idle_mode_t'(ph % 4));
            plan_q.delete();

            for (k = 0; k < 8; k++) v[8*k +: 8] = pick_alpha();
            write_reg(REG_PATTERN_BYTES, (ph == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : v);
            v = {$urandom, $urandom};
            case (ph)
                0:       v[3:0] = 4'd1;
                1:       v      = 64'd8;
                3:       v[3:0] = 4'd0;
                default: v[3:0] = 4'($urandom_range(1, 15));
            endcase
            write_reg(REG_PATTERN_LENGTH, v);
            v = {$urandom, $urandom};
            write_reg(REG_REPLACEMENT_BYTES, (ph == 1) ? 64'h0 : v);
            v = {$urandom, $urandom};
            case (ph)
                0:       v[3:0] = 4'd0;
                1:       v      = 64'd8;
                3:       v[3:0] = 4'hF;
                default: v[3:0] = 4'($urandom_range(0, 15));
            endcase
            write_reg(REG_REPLACEMENT_LENGTH, v);
            cfg_valid <= 1'b0;
            plen = clamp_len(pat_len, 1, MAX_PATTERN);

            for (j = 0; j < ITEMS_PER_PHASE; j++) begin
                // Once, hold the sender back until the block has caught up
                if (ph == 2 && j == ITEMS_PER_PHASE / 2) wait_idle();
                if (plan_q.size() == 0) begin
                    roll = $urandom_range(99);
                    if (roll < 45) begin
                        for (k = 0; k < plen; k++) plan_q.push_back(pat_bytes[8*k +: 8]);
                    end else if (roll < 70 && plen > 1) begin
                        roll = $urandom_range(1, plen - 1);
                        for (k = 0; k < roll; k++)
                            plan_q.push_back(pat_bytes[8*k +: 8]);
                        plan_q.push_back(pick_alpha());
                    end else begin
                        plan_q.push_back(($urandom_range(1)) ? pick_alpha() : 8'($urandom));
                    end
                end
                if ($urandom_range(99) < 5) begin
                    b   = 8'($urandom);
                    emp = 1'b1;
                    e   = 1'($urandom);
                end else begin
                    b   = plan_q.pop_front();
                    emp = 1'b0;
                    e   = ($urandom_range(99) < 8);
                end
                send_item(b, e, emp, FROM_MODEL, '0);
            end
        end

        // --- wind down -----------------------------------------------------
        s_tvalid <= 1'b0;
        while (expected_bytes_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb_top: %0d input transactions, %0d results, %0d register writes",
                 n_items, n_results, n_writes);
        $display("tb_top: %0d random settings under four idling modes, %0d mismatches",
                 N_PHASES, n_errors);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace_core.sv
tb/tb_top.sv
